FILE: sv/assert_macros.svh
// Assertion macros shared by the hashed position table RTL.
// Depends on nothing; the assertion bodies drop out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define HPT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HPT_ASSERT(lbl, clk, rst_n, prop, msg)
`define HPT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: sv/hpt_pkg.sv
// Types and constants for the hashed position table.
// Used by the decision logic and the top level; depends on nothing.
package hpt_pkg;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned MASK_W  = 12;

  localparam logic [1:0] KIND_EXACT = 2'd0;
  localparam logic [1:0] KIND_UPPER = 2'd1;
  localparam logic [1:0] KIND_LOWER = 2'd2;

  typedef enum logic [1:0] {
    OP_SEARCH_SAVE  = 2'd0,
    OP_SEARCH_PROBE = 2'd1,
    OP_PERFT_SAVE   = 2'd2,
    OP_PERFT_PROBE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_IDX1,
    ST_IDX2,
    ST_READ,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic                      valid;
    logic [KEY_W-1:0]          key;
    logic signed [VALUE_W-1:0] value;
    logic [DEPTH_W-1:0]        depth;
    logic [1:0]                kind;
  } entry_t;

  typedef struct packed {
    op_e                       op;
    logic [KEY_W-1:0]          key;
    logic signed [VALUE_W-1:0] value;
    logic [DEPTH_W-1:0]        depth;
    logic [1:0]                kind;
    logic signed [VALUE_W-1:0] alpha;
    logic signed [VALUE_W-1:0] beta;
  } req_t;

  typedef struct packed {
    logic                      wr_en;
    entry_t                    wr_entry;
    logic                      is_probe;
    logic                      hit;
    logic signed [VALUE_W-1:0] value;
  } decide_t;

endpackage

FILE: sv/hashed_position_table_core.sv
// Hashed position table: a probe result is on the result ports for one
// cycle, after the request register, two index stages, RAM read register
// and result registers. A new command is taken only when idle, after the
// previous read-modify-write on the single RAM port. Clearing all ENTRIES
// after reset keeps busy high; configuration writes are taken throughout.
module hashed_position_table_core #(
  parameter int unsigned ENTRIES = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode_i,
  input  logic [63:0]        position_key_i,
  input  logic signed [31:0] entry_value_i,
  input  logic [15:0]        search_depth_i,
  input  logic [1:0]         bound_kind_i,
  input  logic signed [31:0] alpha_bound_i,
  input  logic signed [31:0] beta_bound_i,
  input  logic               cfg_we_i,
  input  logic [11:0]        cfg_data_i,
  output logic               result_valid_o,
  output logic signed [31:0] probe_value_o,
  output logic               probe_hit_o
);
  import hpt_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned IDXW  = $clog2(ENTRIES);
  localparam int unsigned ENT_W = $bits(entry_t);

  state_e            state_q, state_d;
  logic [IDXW-1:0]   clr_q, clr_d;
  logic [11:0]       mask_q;
  req_t              req_q;
  logic              accept;
  logic [IDXW-1:0]   index;
  logic              ram_we, ram_re;
  logic [IDXW-1:0]   ram_addr;
  entry_t            ram_wdata, ram_rdata;
  decide_t           dec;
  logic              emit;
  logic              valid_q;
  logic              hit_q;
  logic signed [31:0] value_q;

  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      mask_q  <= '0;
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (cfg_we_i) begin
        mask_q <= cfg_data_i;
      end
      valid_q <= emit;
      hit_q   <= emit && dec.hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.op    <= op_e'(opcode_i);
      req_q.key   <= position_key_i;
      req_q.value <= entry_value_i;
      req_q.depth <= search_depth_i;
      req_q.kind  <= bound_kind_i;
      req_q.alpha <= alpha_bound_i;
      req_q.beta  <= beta_bound_i;
    end
    if (emit) begin
      value_q <= dec.value;
    end
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == IDXW'(ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_d = ST_IDX1;
        end
      end
      ST_IDX1: state_d = ST_IDX2;
      ST_IDX2: state_d = ST_READ;
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = index;
    ram_wdata = dec.wr_entry;
    emit      = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
      end
      ST_IDLE: busy = 1'b0;
      ST_READ: ram_re = 1'b1;
      ST_EXEC: begin
        ram_we = dec.wr_en;
        emit   = dec.is_probe;
      end
      default: busy = 1'b1;
    endcase
  end

  hpt_index #(
    .ENTRIES(ENTRIES)
  ) u_index (
    .clk_i   (clk_i),
    .masked_i(req_q.key[11:0] & mask_q),
    .index_o (index)
  );

  hpt_ram #(
    .WIDTH(ENT_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  hpt_decide u_decide (
    .req_i    (req_q),
    .entry_i  (ram_rdata),
    .enabled_i(mask_q != '0),
    .dec_o    (dec)
  );

  assign result_valid_o = valid_q;
  assign probe_hit_o    = hit_q;
  assign probe_value_o  = value_q;

  `HPT_ASSERT(a_strobe_after_exec, clk_i, rst_ni, result_valid_o |-> $past(state_q) == ST_EXEC, "result beat without a table access")
  `HPT_ASSERT(a_strobe_single, clk_i, rst_ni, result_valid_o |=> !result_valid_o, "result beat held for two cycles")
  `HPT_ASSERT(a_exec_after_read, clk_i, rst_ni, state_q == ST_EXEC |-> $past(state_q) == ST_READ, "table update without a preceding read")
  `HPT_ASSERT(a_probe_no_write, clk_i, rst_ni, (state_q == ST_EXEC && dec.is_probe) |-> !ram_we, "probe wrote the table")
  `HPT_ASSERT_ALWAYS(a_hit_in_beat, clk_i, probe_hit_o |-> result_valid_o, "hit flag outside a result beat")

endmodule

FILE: sv/hpt_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
module hpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/hpt_index.sv
// Two-stage table index unit: reduces the masked key modulo the entry count.
// Depends on nothing; non-power-of-two sizes below 4096 use a reciprocal multiply.
module hpt_index #(
  parameter int unsigned ENTRIES = 4096
) (
  input  logic                       clk_i,
  input  logic [11:0]                masked_i,
  output logic [$clog2(ENTRIES)-1:0] index_o
);

  localparam int unsigned IDXW  = $clog2(ENTRIES);
  localparam int unsigned SHIFT = 24;
  localparam int unsigned RECIP = ((2 ** SHIFT) + ENTRIES - 1) / ENTRIES;

  logic [11:0] x1_q;

  always_ff @(posedge clk_i) begin
    x1_q <= masked_i;
  end

  if (ENTRIES >= 4096) begin : g_wide
    logic [IDXW-1:0] idx_q;
    always_ff @(posedge clk_i) begin
      idx_q <= IDXW'(x1_q);
    end
    assign index_o = idx_q;
  end else if ((ENTRIES & (ENTRIES - 1)) == 0) begin : g_pow2
    logic [IDXW-1:0] idx_q;
    always_ff @(posedge clk_i) begin
      idx_q <= x1_q[IDXW-1:0];
    end
    assign index_o = idx_q;
  end else begin : g_recip
    logic [35:0]     prod;
    logic [11:0]     quot_q;
    logic [23:0]     qe;
    logic [11:0]     rem;
    logic [IDXW-1:0] idx_q;

    assign prod = masked_i * 24'(RECIP);
    assign qe   = quot_q * 12'(ENTRIES);
    assign rem  = x1_q - qe[11:0];

    always_ff @(posedge clk_i) begin
      quot_q <= prod[35:24];
    end

    always_ff @(posedge clk_i) begin
      idx_q <= rem[IDXW-1:0];
    end

    assign index_o = idx_q;
  end

endmodule

FILE: sv/hpt_decide.sv
// Update and probe decision for one table access.
// Depends on hpt_pkg for the request, entry and decision types.
module hpt_decide (
  input  hpt_pkg::req_t    req_i,
  input  hpt_pkg::entry_t  entry_i,
  input  logic             enabled_i,
  output hpt_pkg::decide_t dec_o
);
  import hpt_pkg::*;

  logic same;

  assign same = entry_i.valid && (entry_i.key == req_i.key);

  always_comb begin
    dec_o                = '0;
    dec_o.wr_entry.valid = 1'b1;
    dec_o.wr_entry.key   = req_i.key;
    dec_o.wr_entry.value = req_i.value;
    dec_o.wr_entry.depth = req_i.depth;
    dec_o.wr_entry.kind  = req_i.kind;
    case (req_i.op)
      OP_SEARCH_SAVE: begin
        dec_o.wr_en = enabled_i && !(same && (entry_i.depth > req_i.depth));
      end
      OP_PERFT_SAVE: begin
        dec_o.wr_en = enabled_i && !(same && (entry_i.depth != req_i.depth));
        dec_o.wr_entry.kind = entry_i.valid ? entry_i.kind : KIND_EXACT;
      end
      OP_SEARCH_PROBE: begin
        dec_o.is_probe = 1'b1;
        if (enabled_i && same && (entry_i.depth >= req_i.depth)) begin
          if (entry_i.kind == KIND_EXACT) begin
            dec_o.hit   = 1'b1;
            dec_o.value = entry_i.value;
          end else if ((entry_i.kind == KIND_UPPER) && (entry_i.value <= req_i.alpha)) begin
            dec_o.hit   = 1'b1;
            dec_o.value = req_i.alpha;
          end else if ((entry_i.kind == KIND_LOWER) && (entry_i.value >= req_i.beta)) begin
            dec_o.hit   = 1'b1;
            dec_o.value = req_i.beta;
          end
        end
      end
      OP_PERFT_PROBE: begin
        dec_o.is_probe = 1'b1;
        if (enabled_i && same && (entry_i.depth == req_i.depth)) begin
          dec_o.hit   = 1'b1;
          dec_o.value = entry_i.value;
        end
      end
      default: begin
        dec_o.wr_en = 1'b0;
      end
    endcase
  end

endmodule

FILE: tb/tb.sv
// Self-checking testbench for hashed_position_table_core: directed and random table commands
// are checked against a shadow copy of the table kept in the testbench.
// Depends on hpt_pkg and the hashed_position_table_core RTL.
module tb;
  import hpt_pkg::*;

  localparam int ENTRY_COUNT = 4096;
  localparam int KEY_POOL_SIZE = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [1:0] KIND_RESERVED = 2'd3;

  typedef struct {
    op_e         op;
    logic [63:0] key;
    int          value;
    logic [15:0] depth;
    logic [1:0]  kind;
    int          alpha;
    int          beta;
  } table_cmd_t;

  typedef struct {
    int value;
    bit hit;
    bit checked;
  } probe_outcome_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         opcode_i;
  logic [63:0]        position_key_i;
  logic signed [31:0] entry_value_i;
  logic [15:0]        search_depth_i;
  logic [1:0]         bound_kind_i;
  logic signed [31:0] alpha_bound_i;
  logic signed [31:0] beta_bound_i;
  logic               cfg_we_i;
  logic [11:0]        cfg_data_i;
  logic               result_valid_o;
  logic signed [31:0] probe_value_o;
  logic               probe_hit_o;

  hashed_position_table_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .position_key_i (position_key_i),
    .entry_value_i  (entry_value_i),
    .search_depth_i (search_depth_i),
    .bound_kind_i   (bound_kind_i),
    .alpha_bound_i  (alpha_bound_i),
    .beta_bound_i   (beta_bound_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .probe_value_o  (probe_value_o),
    .probe_hit_o    (probe_hit_o)
  );

  // Shadow copy of the table. A bound kind is unknown after a perft save
  // into an empty slot, so search probes that depend on it are not checked.
  logic [63:0] shadow_key[ENTRY_COUNT];
  int          shadow_value[ENTRY_COUNT];
  logic [15:0] shadow_depth[ENTRY_COUNT];
  logic [1:0]  shadow_kind[ENTRY_COUNT];
  bit          shadow_kind_known[ENTRY_COUNT];
  bit          shadow_valid[ENTRY_COUNT];
  logic [11:0] shadow_mask;

  table_cmd_t     commands_to_issue[$];
  probe_outcome_t probe_results_due[$];
  table_cmd_t     issued_cmd;
  table_cmd_t     next_cmd;
  probe_outcome_t accepted_outcome;
  probe_outcome_t due_outcome;
  bit             accepted_produces;
  int             sender_idle_pct;
  int             failure_count;
  int             cycle_count;
  logic [63:0]    key_pool[KEY_POOL_SIZE];

  function automatic void predict_table_access(input table_cmd_t c, output bit produces,
                                               output probe_outcome_t outcome);
    int unsigned idx;
    bit enabled;
    bit same;
    idx = 32'(c.key[11:0] & shadow_mask);
    enabled = shadow_mask != 0;
    same = shadow_valid[idx] && shadow_key[idx] == c.key;
    produces = 1'b0;
    outcome = '{value: 0, hit: 1'b0, checked: 1'b1};
    if (c.op == OP_SEARCH_SAVE || c.op == OP_PERFT_SAVE) begin
      if (!enabled) return;
      if (c.op == OP_SEARCH_SAVE) begin
        if (same && shadow_depth[idx] > c.depth) return;
        shadow_kind[idx] = c.kind;
        shadow_kind_known[idx] = 1'b1;
      end else begin
        if (same && shadow_depth[idx] != c.depth) return;
        if (!shadow_valid[idx]) shadow_kind_known[idx] = 1'b0;
      end
      shadow_key[idx] = c.key;
      shadow_value[idx] = c.value;
      shadow_depth[idx] = c.depth;
      shadow_valid[idx] = 1'b1;
      return;
    end
    produces = 1'b1;
    if (enabled && same) begin
      if (c.op == OP_SEARCH_PROBE) begin
        if (shadow_depth[idx] >= c.depth) begin
          if (!shadow_kind_known[idx]) begin
            outcome.checked = 1'b0;
          end else if (shadow_kind[idx] == KIND_EXACT) begin
            outcome.hit = 1'b1;
            outcome.value = shadow_value[idx];
          end else if (shadow_kind[idx] == KIND_UPPER && shadow_value[idx] <= c.alpha) begin
            outcome.hit = 1'b1;
            outcome.value = c.alpha;
          end else if (shadow_kind[idx] == KIND_LOWER && shadow_value[idx] >= c.beta) begin
            outcome.hit = 1'b1;
            outcome.value = c.beta;
          end
        end
      end else if (shadow_depth[idx] == c.depth) begin
        outcome.hit = 1'b1;
        outcome.value = shadow_value[idx];
      end
    end
  endfunction

  function automatic table_cmd_t make_cmd(op_e op, logic [63:0] key, int value,
                                          logic [15:0] depth, logic [1:0] kind,
                                          int alpha, int beta);
    table_cmd_t c;
    c = '{op: op, key: key, value: value, depth: depth, kind: kind, alpha: alpha, beta: beta};
    return c;
  endfunction

  function automatic int random_score();
    int s;
    if ($urandom_range(99) < 70) s = int'($urandom_range(16)) - 8;
    else s = $urandom;
    return s;
  endfunction

  function automatic table_cmd_t random_cmd();
    table_cmd_t c;
    c.op = op_e'($urandom_range(3));
    if ($urandom_range(99) < 80) c.key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
    else c.key = {$urandom, $urandom};
    c.value = random_score();
    if ($urandom_range(99) < 85) c.depth = 16'($urandom_range(3));
    else c.depth = 16'($urandom);
    c.kind = 2'($urandom_range(3));
    c.alpha = random_score();
    c.beta = random_score();
    return c;
  endfunction

  // About half of the replaced keys share their low bits with the first pool key,
  // so different positions fight over the same slot.
  task automatic refresh_key_pool(int count);
    int j;
    logic [63:0] k;
    for (int i = 0; i < count; i++) begin
      j = $urandom_range(KEY_POOL_SIZE - 1);
      k = {$urandom, $urandom};
      if ($urandom_range(1) == 1) k[11:0] = key_pool[0][11:0];
      key_pool[j] = k;
    end
  endtask

  task automatic note_failure(string what);
    failure_count++;
    if (failure_count <= 10) $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  task automatic wait_until_idle();
    do @(posedge clk_i);
    while (commands_to_issue.size() != 0 || start || probe_results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_index_mask(logic [11:0] mask);
    cfg_we_i <= 1'b1;
    cfg_data_i <= mask;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_mask = mask;
  endtask

  task automatic run_random_phase(logic [11:0] mask, int idle_pct, int count);
    write_index_mask(mask);
    sender_idle_pct = idle_pct;
    refresh_key_pool(3);
    for (int i = 0; i < count; i++) commands_to_issue.push_back(random_cmd());
    wait_until_idle();
  endtask

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      opcode_i <= OP_SEARCH_SAVE;
      position_key_i <= '0;
      entry_value_i <= '0;
      search_depth_i <= '0;
      bound_kind_i <= KIND_EXACT;
      alpha_bound_i <= '0;
      beta_bound_i <= '0;
    end else begin
      if (start && !busy) begin
        predict_table_access(issued_cmd, accepted_produces, accepted_outcome);
        if (accepted_produces) probe_results_due.push_back(accepted_outcome);
      end
      if (!start || !busy) begin
        if (commands_to_issue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_cmd = commands_to_issue.pop_front();
          start <= 1'b1;
          opcode_i <= next_cmd.op;
          position_key_i <= next_cmd.key;
          entry_value_i <= next_cmd.value;
          search_depth_i <= next_cmd.depth;
          bound_kind_i <= next_cmd.kind;
          alpha_bound_i <= next_cmd.alpha;
          beta_bound_i <= next_cmd.beta;
          issued_cmd <= next_cmd;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (probe_results_due.size() == 0) begin
        note_failure($sformatf("unexpected result value %0d hit %0b",
                               probe_value_o, probe_hit_o));
      end else begin
        due_outcome = probe_results_due.pop_front();
        if (due_outcome.checked && (probe_value_o !== due_outcome.value ||
                                    probe_hit_o !== due_outcome.hit)) begin
          note_failure($sformatf("expected value %0d hit %0b, got value %0d hit %0b",
                                 due_outcome.value, due_outcome.hit,
                                 probe_value_o, probe_hit_o));
        end
      end
    end
  end

  initial begin
    logic [63:0] k1, k2, k3, k4, k5;
    k1 = 64'h0123_4567_89AB_C010;
    k2 = k1 ^ 64'h0000_0100_0000_0000;
    k3 = 64'hFEDC_BA98_7654_3021;
    k4 = 64'h8000_0000_0000_0FFE;
    k5 = 64'h0000_0000_0000_0FFE;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    sender_idle_pct = 0;
    failure_count = 0;
    cycle_count = 0;
    shadow_mask = '0;
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_kind_known[i] = 1'b0;
    end
    for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i);
    while (busy);

    // The table comes out of reset disabled.
    commands_to_issue.push_back(make_cmd(OP_SEARCH_SAVE, k1, 100, 5, KIND_EXACT, 0, 0));
    commands_to_issue.push_back(make_cmd(OP_SEARCH_PROBE, k1, 0, 5, KIND_EXACT, 0, 0));
    wait_until_idle();

    write_index_mask(12'hFFF);
    commands_to_issue.push_back(make_cmd(OP_SEARCH_SAVE, k1, 100, 5, KIND_EXACT, 0, 0));
    commands_to_issue.push_back(make_cmd(OP_SEARCH_PROBE, k1, 0, 5, KIND_EXACT, 0, 0));
    commands_to_issue.push_back(make_cmd(OP_SEARCH_PROBE, k1, 0, 6, KIND_EXACT, 0, 0));
    commands_to_issue.push_back(make_cmd(OP_SEARCH_SAVE, k1, 7, 3, KIND_EXACT, 0, 0));
    commands_to_issue.push_back(make_cmd(OP_SEARCH_PROBE, k1, 0, 0, KIND_EXACT, 0, 0));
    commands_to_issue.push_back(make_cmd(OP_SEARCH_SAVE, k1, 32'sh8000_0000, 16'hFFFF,
                                         KIND_UPPER, 0, 0));
    commands_to_issue.push_back(make_cmd(OP_SEARCH_PROBE, k1, 0, 16'hFFFF, KIND_EXACT,
                                         32'sh7FFF_FFFF, 0));
    commands_to_issue.push_back(make_cmd(OP_SEARCH_SAVE, k1, -5, 16'hFFFF, KIND_UPPER, 0, 0));
    commands_to_issue.push_back(make_cmd(OP_SEARCH_PROBE, k1, 0, 16'hFFFF, KIND_EXACT,
                                         32'sh8000_0000, 0));
    commands_to_issue.push_back(make_cmd(OP_SEARCH_SAVE, k2, 32'sh7FFF_FFFF, 0, KIND_LOWER,
                                         0, 0));
    commands_to_issue.push_back(make_cmd(OP_SEARCH_PROBE, k1, 0, 0, KIND_EXACT, 0, 0));
    commands_to_issue.push_back(make_cmd(OP_SEARCH_PROBE, k2, 0, 0, KIND_EXACT, 0,
                                         32'sh7FFF_FFFF));
    commands_to_issue.push_back(make_cmd(OP_SEARCH_SAVE, k3, 9, 2, KIND_RESERVED, 0, 0));
    commands_to_issue.push_back(make_cmd(OP_SEARCH_PROBE, k3, 0, 2, KIND_EXACT, -100, 100));
    commands_to_issue.push_back(make_cmd(OP_PERFT_SAVE, k4, 12345, 4, KIND_EXACT, 0, 0));
    commands_to_issue.push_back(make_cmd(OP_PERFT_PROBE, k4, 0, 4, KIND_EXACT, 0, 0));
    commands_to_issue.push_back(make_cmd(OP_PERFT_PROBE, k4, 0, 3, KIND_EXACT, 0, 0));
    commands_to_issue.push_back(make_cmd(OP_PERFT_SAVE, k4, 999, 5, KIND_EXACT, 0, 0));
    commands_to_issue.push_back(make_cmd(OP_PERFT_PROBE, k4, 0, 4, KIND_EXACT, 0, 0));
    commands_to_issue.push_back(make_cmd(OP_PERFT_SAVE, k5, -1, 9, KIND_EXACT, 0, 0));
    commands_to_issue.push_back(make_cmd(OP_PERFT_PROBE, k5, 0, 9, KIND_EXACT, 0, 0));
    commands_to_issue.push_back(make_cmd(OP_SEARCH_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0,
                                         KIND_EXACT, 0, 0));
    wait_until_idle();

    run_random_phase(12'hFFF, 0, 100);
    run_random_phase(12'h00F, 46, 100);
    run_random_phase(12'hA5A, 0, 100);
    run_random_phase(12'h001, 32, 100);
    run_random_phase(12'hFFF, 46, 100);
    run_random_phase(12'h000, 0, 30);

    if (failure_count == 0 && probe_results_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: hashed_position_table_core.f
+incdir+sv
sv/hpt_pkg.sv
sv/hpt_ram.sv
sv/hpt_index.sv
sv/hpt_decide.sv
sv/hashed_position_table_core.sv
tb/tb.sv
